[design/first_fit_allocator_compaction_unit_defines.svh]
// Assertion helpers used by the checker file.
`ifndef FIRST_FIT_ALLOCATOR_COMPACTION_UNIT_DEFINES_SVH
`define FIRST_FIT_ALLOCATOR_COMPACTION_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define FFAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define FFAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ffac_pkg.sv]
`default_nettype none

package ffac_pkg;

    localparam int CELLS_DEF   = 128;
    localparam int ID_BITS_DEF = 16;

    localparam int SIZE_W    = 8;
    localparam int BID_W     = 16;
    localparam int NID_W     = 16;
    localparam int CFG_W     = 8;
    localparam int USER_W    = 2;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_ERASE  = 2'd1,
        OP_DEFRAG = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_ALLOCATED = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_ILLEGAL   = 2'd2,
        STAT_DONE      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_FILL,
        ST_ERASE,
        ST_DEFRAG,
        ST_ZERO,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_CLEAR,
        MODE_ALLOC,
        MODE_FILL,
        MODE_ERASE,
        MODE_DEFRAG,
        MODE_ZERO
    } mode_t;

    typedef struct packed {
        logic    accept;
        logic    issue;
        mode_t   mode;
        logic    bump;
        logic    post;
        status_t post_status;
    } cmd_t;

    typedef struct packed {
        logic issue_done;
        logic pipe_vld;
        logic found;
        logic fill_last;
        logic zero_done;
        logic clear_last;
        logic hit;
        logic early_no_space;
        logic id_zero;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

[design/ffac_ctrl.sv]
`default_nettype none

module ffac_ctrl import ffac_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [USER_W-1:0] op_in,
    input  wire sts_t              sts,
    output cmd_t                   cmd
);

    state_t  state_reg, state_next;
    status_t res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            res_reg   <= STAT_DONE;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        res_next        = res_reg;
        s_tready        = 1'b0;
        cmd.accept      = 1'b0;
        cmd.issue       = 1'b0;
        cmd.mode        = MODE_IDLE;
        cmd.bump        = 1'b0;
        cmd.post        = 1'b0;
        cmd.post_status = res_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.mode = MODE_CLEAR;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    case (op_in)
                        OP_ALLOC: state_next = ST_ALLOC;
                        OP_ERASE: state_next = ST_ERASE;
                        default:  state_next = ST_DEFRAG;
                    endcase
                end
            end
            ST_ALLOC: begin
                cmd.mode = MODE_ALLOC;
                if (sts.early_no_space) begin
                    res_next   = STAT_NO_SPACE;
                    state_next = ST_RESULT;
                end else if (sts.found) begin
                    state_next = ST_FILL;
                end else if (sts.issue_done && !sts.pipe_vld) begin
                    res_next   = STAT_NO_SPACE;
                    state_next = ST_RESULT;
                end else begin
                    cmd.issue = !sts.issue_done;
                end
            end
            ST_FILL: begin
                cmd.mode = MODE_FILL;
                if (sts.fill_last) begin
                    cmd.bump   = 1'b1;
                    res_next   = STAT_ALLOCATED;
                    state_next = ST_RESULT;
                end
            end
            ST_ERASE: begin
                cmd.mode = MODE_ERASE;
                if (sts.id_zero) begin
                    res_next   = STAT_ILLEGAL;
                    state_next = ST_RESULT;
                end else if (sts.issue_done && !sts.pipe_vld) begin
                    res_next   = sts.hit ? STAT_DONE : STAT_ILLEGAL;
                    state_next = ST_RESULT;
                end else begin
                    cmd.issue = !sts.issue_done;
                end
            end
            ST_DEFRAG: begin
                cmd.mode = MODE_DEFRAG;
                if (sts.issue_done && !sts.pipe_vld) begin
                    state_next = ST_ZERO;
                end else begin
                    cmd.issue = !sts.issue_done;
                end
            end
            ST_ZERO: begin
                cmd.mode = MODE_ZERO;
                if (sts.zero_done) begin
                    res_next   = STAT_DONE;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!sts.out_busy) begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/ffac_dp.sv]
`default_nettype none

module ffac_dp import ffac_pkg::*; #(
    parameter int CELLS   = CELLS_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wen,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic [USER_W-1:0]        m_tuser
);

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW = $clog2(CELLS + 1);
    localparam int MW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int XW = ID_BITS + BID_W;

    logic [ID_BITS-1:0] mem [CELLS];

    logic [CFG_W-1:0]   cfg_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [BID_W-1:0]   bid_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      pidx_reg;
    logic               pvld_reg;
    logic [ID_BITS-1:0] rdata_reg;
    logic [CW-1:0]      run_reg;
    logic [CW-1:0]      wptr_reg;
    logic [CW-1:0]      fend_reg;
    logic               hit_reg;
    logic               found_reg;
    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [NID_W-1:0]   m_id_reg;

    logic [CW-1:0]      n_cnt;
    logic [CW-1:0]      run_inc;
    logic [CW-1:0]      fill_start;
    logic [ID_BITS-1:0] id_inc;
    logic [XW-1:0]      id_ext;
    logic               free;
    logic               fit;
    logic               erase_hit;
    logic               proc_alloc;
    logic               zero_more;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [ID_BITS-1:0] wdata;

    assign n_cnt      = (MW'(cfg_reg) > MW'(CELLS)) ? CW'(CELLS) : CW'(cfg_reg);
    assign run_inc    = run_reg + CW'(1);
    assign free       = (rdata_reg == '0);
    assign fit        = free && (MW'(run_inc) == MW'(size_reg));
    assign erase_hit  = (XW'(rdata_reg) == XW'(bid_reg));
    assign id_inc     = id_reg + ID_BITS'(1);
    assign id_ext     = XW'(id_reg);
    assign fill_start = pidx_reg + CW'(1) - CW'(size_reg);
    assign proc_alloc = (cmd.mode == MODE_ALLOC) && pvld_reg && !found_reg;
    assign zero_more  = (wptr_reg < n_cnt);

    always_comb begin
        we    = 1'b0;
        waddr = wptr_reg[AW-1:0];
        wdata = '0;
        case (cmd.mode)
            MODE_CLEAR: we = 1'b1;
            MODE_FILL: begin
                we    = 1'b1;
                wdata = id_inc;
            end
            MODE_ERASE: begin
                we    = pvld_reg && erase_hit;
                waddr = pidx_reg[AW-1:0];
            end
            MODE_DEFRAG: begin
                we    = pvld_reg && !free;
                wdata = rdata_reg;
            end
            MODE_ZERO: we = zero_more;
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.issue) begin
            rdata_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg <= idx_reg;
        if (cmd.accept) begin
            size_reg <= s_tdata[SIZE_W-1:0];
            bid_reg  <= s_tdata[SIZE_W+BID_W-1:SIZE_W];
        end
        if (proc_alloc && fit) begin
            fend_reg <= pidx_reg;
        end
        if (cmd.post) begin
            m_status_reg <= cmd.post_status;
            m_id_reg     <= (cmd.post_status == STAT_ALLOCATED) ? id_ext[NID_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= CFG_RESET;
            id_reg      <= '0;
            idx_reg     <= '0;
            pvld_reg    <= 1'b0;
            run_reg     <= '0;
            wptr_reg    <= '0;
            hit_reg     <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                cfg_reg <= cfg_wdata;
            end
            pvld_reg <= cmd.issue;
            if (cmd.accept) begin
                idx_reg   <= '0;
                run_reg   <= '0;
                wptr_reg  <= '0;
                hit_reg   <= 1'b0;
                found_reg <= 1'b0;
            end else begin
                if (cmd.issue) begin
                    idx_reg <= idx_reg + CW'(1);
                end
                case (cmd.mode)
                    MODE_ALLOC: begin
                        if (proc_alloc) begin
                            run_reg <= free ? run_inc : '0;
                            if (fit) begin
                                found_reg <= 1'b1;
                                wptr_reg  <= fill_start;
                            end
                        end
                    end
                    MODE_FILL: wptr_reg <= wptr_reg + CW'(1);
                    MODE_ERASE: begin
                        if (pvld_reg && erase_hit) begin
                            hit_reg <= 1'b1;
                        end
                    end
                    MODE_DEFRAG: begin
                        if (pvld_reg && !free) begin
                            wptr_reg <= wptr_reg + CW'(1);
                        end
                    end
                    MODE_ZERO: begin
                        if (zero_more) begin
                            wptr_reg <= wptr_reg + CW'(1);
                        end
                    end
                    MODE_CLEAR: wptr_reg <= wptr_reg + CW'(1);
                    default: wptr_reg <= wptr_reg;
                endcase
            end
            if (cmd.bump) begin
                id_reg <= id_inc;
            end
            if (cmd.post) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.issue_done     = (idx_reg == n_cnt);
    assign sts.pipe_vld       = pvld_reg;
    assign sts.found          = found_reg;
    assign sts.fill_last      = (wptr_reg == fend_reg);
    assign sts.zero_done      = !zero_more;
    assign sts.clear_last     = (wptr_reg == CW'(CELLS - 1));
    assign sts.hit            = hit_reg;
    assign sts.early_no_space = (size_reg == '0) || (id_reg == '1);
    assign sts.id_zero        = (bid_reg == '0);
    assign sts.out_busy       = m_valid_reg && !m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_id_reg;
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

[design/first_fit_allocator_compaction_unit.sv]
// Channel   Ports              Payload
// s_        tvalid/tready      tuser: op; tdata: alloc_size, block_id
// m_        tvalid/tready      tuser: status; tdata: new_id
// cfg_      wen/wdata          cells_in_use, written at any edge with wen high
//
// After reset the cell store is cleared, one cell a cycle, with s_tready low until all CELLS are clear.
// An alloc scans the active cells (n = active cells) until a run fits, then fills alloc_size
// cells; an erase scans all n cells. Defragment compacts, then zeroes the cells left free.
// Zero size, spent ids or id 0 end the request without a scan.
// The scan does one read and one write per cycle; s_tready is high only when idle.
// A result waits in the output register; a stalled m_ side holds the next result back.
`default_nettype none

module first_fit_allocator_compaction_unit import ffac_pkg::*; #(
    parameter int CELLS   = CELLS_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // alloc_size[7:0], block_id[23:8]
    input  wire logic [USER_W-1:0]   s_tuser,   // op[1:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // new_id[15:0]
    output logic [USER_W-1:0]        m_tuser,   // status[1:0]
    input  wire logic                cfg_wen,
    input  wire logic [CFG_W-1:0]    cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    ffac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op_in    (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffac_dp #(
        .CELLS   (CELLS),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

[design/ffac_sva.sv]
`default_nettype none
`include "first_fit_allocator_compaction_unit_defines.svh"

module ffac_sva import ffac_pkg::*; (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [USER_W-1:0]   s_tuser,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [USER_W-1:0]   m_tuser
);

    // one request in flight at a time
    `FFAC_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second beat taken while busy")

    // every request passes through a decision state before its result is posted
    `FFAC_ASSERT_NXT(a_no_instant_result, aclk, aresetn, s_tvalid && s_tready, !$rose(m_tvalid), "result rose right after accept")

    `FFAC_ASSERT_IMP(a_id_zero_on_fail, aclk, aresetn, m_tvalid && (m_tuser != STAT_ALLOCATED), m_tdata == '0, "nonzero new_id without allocation")

    `FFAC_ASSERT_NXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind first_fit_allocator_compaction_unit ffac_sva u_sva (.*);

`default_nettype wire

[verif/tb_first_fit_allocator_compaction_unit.sv]
`timescale 1ns / 1ps

module tb_first_fit_allocator_compaction_unit;
    import ffac_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;   // unused code, decodes as defragment
    localparam int WATCHDOG_LIMIT    = 20000;
    localparam int HOLD_CYCLES       = 3000;
    localparam int MAX_REPORTS       = 50;
    localparam int DRAIN_CYCLES      = 300;
    localparam int DIR_ROWS          = 25;

    typedef struct packed {
        status_t           status;
        logic [NID_W-1:0]  new_id;
    } reply_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [SIZE_W-1:0] size;
        logic [BID_W-1:0]  bid;
        logic              typed;
        status_t           status;
        logic [NID_W-1:0]  new_id;
    } dir_row_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // alloc_size[7:0], block_id[23:8]
    logic [USER_W-1:0]   s_tuser   = '0;   // op[1:0]
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // new_id[15:0]
    logic [USER_W-1:0]   m_tuser;          // status[1:0]
    logic                cfg_wen   = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    // shadow of the cell store
    logic [NID_W-1:0] owner_shadow [CELLS_DEF];
    logic [NID_W-1:0] last_id_shadow;
    logic [CFG_W-1:0] cells_shadow;

    reply_t   pending_replies [$];
    dir_row_t dir_rows [DIR_ROWS];
    int       cell_plan [12] = '{8, 0, 255, 32, 1, 128, 16, 4, 129, 64, 2, 0};

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int mismatch_count  = 0;
    int replies_checked = 0;
    int n_alloc  = 0;
    int n_erase  = 0;
    int n_defrag = 0;
    int n_cfg    = 0;

    first_fit_allocator_compaction_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int active_cells();
        return (cells_shadow > CELLS_DEF) ? CELLS_DEF : int'(cells_shadow);
    endfunction

    function automatic reply_t apply_request(input logic [1:0] op,
                                             input logic [SIZE_W-1:0] size,
                                             input logic [BID_W-1:0] bid);
        reply_t r;
        int     n;
        int     run;
        int     wr;
        int     i;
        int     k;
        bit     hit;
        n = active_cells();
        r.status = STAT_DONE;
        r.new_id = '0;
        case (op)
            OP_ALLOC: begin
                r.status = STAT_NO_SPACE;
                if (size != '0 && last_id_shadow != '1) begin
                    run = 0;
                    for (i = 0; i < n; i++) begin
                        if (owner_shadow[i] == '0) run++;
                        else run = 0;
                        if (run == int'(size)) begin
                            last_id_shadow = last_id_shadow + 1'b1;
                            for (k = i + 1 - run; k <= i; k++)
                                owner_shadow[k] = last_id_shadow;
                            r.status = STAT_ALLOCATED;
                            r.new_id = last_id_shadow;
                            break;
                        end
                    end
                end
            end
            OP_ERASE: begin
                hit = 1'b0;
                if (bid != '0) begin
                    for (i = 0; i < n; i++) begin
                        if (owner_shadow[i] == bid) begin
                            owner_shadow[i] = '0;
                            hit = 1'b1;
                        end
                    end
                end
                r.status = hit ? STAT_DONE : STAT_ILLEGAL;
            end
            default: begin
                wr = 0;
                for (i = 0; i < n; i++) begin
                    if (owner_shadow[i] != '0) begin
                        owner_shadow[wr] = owner_shadow[i];
                        wr++;
                    end
                end
                for (; wr < n; wr++)
                    owner_shadow[wr] = '0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [BID_W-1:0] pick_live_id(input int n);
        int start;
        int k;
        if (n == 0) return '0;
        start = $urandom_range(n - 1);
        for (k = 0; k < n; k++)
            if (owner_shadow[(start + k) % n] != '0) return owner_shadow[(start + k) % n];
        return '0;
    endfunction

    task automatic send_req(input logic [1:0] op, input logic [SIZE_W-1:0] size,
                            input logic [BID_W-1:0] bid, input bit typed,
                            input status_t typed_status, input logic [NID_W-1:0] typed_id);
        reply_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {bid, size};
        do @(posedge aclk); while (!s_tready);
        want = apply_request(op, size, bid);
        if (typed) begin
            want.status = typed_status;
            want.new_id = typed_id;
        end
        pending_replies = {pending_replies, want};
        case (op)
            OP_ALLOC: n_alloc++;
            OP_ERASE: n_erase++;
            default:  n_defrag++;
        endcase
    endtask

    task automatic send_random_request();
        int               n;
        int               hi;
        int               pick;
        logic [SIZE_W-1:0] size;
        logic [BID_W-1:0]  bid;
        n    = active_cells();
        hi   = (n >= 8) ? n / 4 : ((n == 0) ? 1 : n);
        pick = $urandom_range(99);
        size = SIZE_W'($urandom_range(255));
        bid  = BID_W'($urandom_range(16'hFFFF));
        if (pick < 45) begin
            case ($urandom_range(9))
                0: size = SIZE_W'($urandom_range(255));
                1: size = (n == 0) ? 8'd1 : n[SIZE_W-1:0];
                default: size = SIZE_W'($urandom_range(hi, 1));
            endcase
            send_req(OP_ALLOC, size, bid, 1'b0, STAT_DONE, '0);
        end else if (pick < 80) begin
            bid = pick_live_id(n);
            if (bid == '0 || $urandom_range(7) == 0) begin
                case ($urandom_range(3))
                    0: bid = '0;
                    1: bid = last_id_shadow - BID_W'($urandom_range(3));
                    default: bid = BID_W'($urandom_range(16'hFFFF));
                endcase
            end
            send_req(OP_ERASE, size, bid, 1'b0, STAT_DONE, '0);
        end else if (pick < 95) begin
            send_req(OP_DEFRAG, size, bid, 1'b0, STAT_DONE, '0);
        end else begin
            send_req(OP_SPARE, size, bid, 1'b0, STAT_DONE, '0);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic write_cells(input logic [CFG_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen      <= 1'b0;
        cells_shadow = value;
        n_cfg++;
    endtask

    // result side: random ready, plus a long hold when requested
    initial begin : recv_side
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_served++;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_replies
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            replies_checked++;
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $error("unexpected beat: status %0d new_id %0d", m_tuser, m_tdata);
            end else begin
                want = pending_replies.pop_front();
                if (m_tuser !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                end
                if (m_tdata !== want.new_id) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $error("new_id: expected %0d, got %0d", want.new_id, m_tdata);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int r;
        int mode;
        int ph;
        int cells;
        int n_items;
        foreach (owner_shadow[r]) owner_shadow[r] = '0;
        last_id_shadow = '0;
        cells_shadow   = CFG_RESET;

        dir_rows = '{
            '{OP_ALLOC,  8'd0,   16'hFFFF, 1'b1, STAT_NO_SPACE,  16'd0},
            '{OP_ALLOC,  8'd1,   16'h0000, 1'b1, STAT_ALLOCATED, 16'd1},
            '{OP_ALLOC,  8'd128, 16'h0000, 1'b1, STAT_NO_SPACE,  16'd0},
            '{OP_ALLOC,  8'd127, 16'hFFFF, 1'b1, STAT_ALLOCATED, 16'd2},
            '{OP_ALLOC,  8'd255, 16'h0000, 1'b1, STAT_NO_SPACE,  16'd0},
            '{OP_ERASE,  8'd255, 16'h0000, 1'b1, STAT_ILLEGAL,   16'd0},
            '{OP_ERASE,  8'd0,   16'hFFFF, 1'b1, STAT_ILLEGAL,   16'd0},
            '{OP_ERASE,  8'd0,   16'd1,    1'b1, STAT_DONE,      16'd0},
            '{OP_ERASE,  8'd0,   16'd1,    1'b1, STAT_ILLEGAL,   16'd0},
            '{OP_DEFRAG, 8'd255, 16'hFFFF, 1'b1, STAT_DONE,      16'd0},
            '{OP_ALLOC,  8'd1,   16'h0000, 1'b1, STAT_ALLOCATED, 16'd3},
            '{OP_ERASE,  8'd0,   16'd2,    1'b1, STAT_DONE,      16'd0},
            '{OP_SPARE,  8'd0,   16'h0000, 1'b1, STAT_DONE,      16'd0},
            '{OP_ALLOC,  8'd128, 16'h0000, 1'b1, STAT_NO_SPACE,  16'd0},
            '{OP_ALLOC,  8'd127, 16'h0000, 1'b1, STAT_ALLOCATED, 16'd4},
            '{OP_ERASE,  8'd0,   16'd3,    1'b1, STAT_DONE,      16'd0},
            '{OP_ALLOC,  8'd2,   16'h0000, 1'b1, STAT_NO_SPACE,  16'd0},
            '{OP_ALLOC,  8'd1,   16'h0000, 1'b1, STAT_ALLOCATED, 16'd5},
            '{OP_ERASE,  8'd0,   16'd4,    1'b0, STAT_DONE,      16'd0},
            '{OP_ALLOC,  8'd64,  16'h0000, 1'b0, STAT_DONE,      16'd0},
            '{OP_ALLOC,  8'd40,  16'h0000, 1'b0, STAT_DONE,      16'd0},
            '{OP_ERASE,  8'd0,   16'hAAAA, 1'b1, STAT_ILLEGAL,   16'd0},
            '{OP_ERASE,  8'd0,   16'h5555, 1'b1, STAT_ILLEGAL,   16'd0},
            '{OP_DEFRAG, 8'd0,   16'h0000, 1'b0, STAT_DONE,      16'd0},
            '{OP_ERASE,  8'd0,   16'd5,    1'b0, STAT_DONE,      16'd0}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 72;
        for (r = 0; r < DIR_ROWS; r++)
            send_req(dir_rows[r].op, dir_rows[r].size, dir_rows[r].bid, dir_rows[r].typed,
                     dir_rows[r].status, dir_rows[r].new_id);

        // three idling regimes, four cell-count settings each
        for (mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 72 : 0;
            recv_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 36 : 0;
            for (ph = 0; ph < 4; ph++) begin
                drain();
                cells = (mode == 2 && ph == 3) ? $urandom_range(127, 3) : cell_plan[mode * 4 + ph];
                write_cells(cells[CFG_W-1:0]);
                if (mode == 2 && ph == 0) hold_requests++;
                n_items = (cells >= 64) ? 60 : 130;
                repeat (n_items) send_random_request();
            end
        end

        // full store again: compact, then one more alloc
        drain();
        write_cells(8'd128);
        send_req(OP_DEFRAG, 8'd0, 16'h0000, 1'b0, STAT_DONE, '0);
        send_req(OP_ALLOC, 8'd1, 16'h0000, 1'b0, STAT_DONE, '0);
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_replies.size() != 0) begin
            $error("%0d replies never arrived", pending_replies.size());
            mismatch_count++;
        end
        $display("Covered %0d requests (%0d alloc, %0d erase, %0d defragment) over %0d cell counts,",
                 n_alloc + n_erase + n_defrag, n_alloc, n_erase, n_defrag, n_cfg);
        $display("  %0d replies checked; three idling mixes; one %0d-cycle output hold.",
                 replies_checked, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
